/* rtl/triangle_face_normal_unit_assert.svh */
// Assertion macros for the triangle face normal unit.
// Uses clk_i and rst_ni of the module that includes it.
`ifndef TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH
`define TRIANGLE_FACE_NORMAL_UNIT_ASSERT_SVH

// Whenever cond holds, prop must hold in the same cycle.
`define TFN_ASSERT_IMPLY(lbl, cond, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> (prop)) \
    else $error("tfn: implication check failed");

// Whenever cond holds, prop must hold after the delay given by n.
`define TFN_ASSERT_DELAY(lbl, cond, n, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond) |-> ##(n) (prop)) \
    else $error("tfn: latency check failed");

`endif

/* rtl/tfn_pkg.sv */
// Shared constants and types of the triangle face normal unit.
// No dependencies.
package tfn_pkg;

  localparam int FaceBits   = 16;
  localparam int ScaledBits = 31;   // scaled cross magnitudes stay below 2^31
  localparam int RadBits    = 64;   // sum of three squares
  localparam int RootBits   = 32;
  localparam int QBits      = 15;   // quotient magnitude, at most 16384
  localparam int NumBits    = 48;   // 32768 * m + s
  localparam int DenBits    = 33;   // 2 * s
  localparam int NormBits   = 16;
  localparam int SqrtLat    = RootBits;
  localparam int DivLat     = QBits;
  localparam int PipeLatency = 8 + SqrtLat + 1 + DivLat + 1;

  typedef struct packed {
    logic [FaceBits-1:0]               face;
    logic [2:0]                        neg;
    logic [2:0][ScaledBits-1:0]        mag;
    logic                              degen;
  } side_t;

  typedef struct packed {
    logic [FaceBits-1:0] face;
    logic [2:0]          neg;
    logic                degen;
  } tail_t;

endpackage

/* rtl/triangle_face_normal_unit.sv */
// Top level of the triangle face normal unit: edge vectors, cross product,
// block scaling, length and division. Depends on tfn_pkg, tfn_sqrt_pipe,
// tfn_div_pipe and triangle_face_normal_unit_assert.svh.
//
//   channel   ports                                        transfer
//   input     start, busy, face_index_i, first/second/third_*_i   start & !busy
//   result    valid_o, out_face_index_o, normal_*_o, degenerate_o  valid_o, one cycle
//
// One face enters every cycle; busy stays low because nothing downstream can
// stall. A result passes through the cross product and scaling stages, the 32
// square root stages, a setup register, the 15 divider stages and the output
// register. Reset clears only the valid bits.
module triangle_face_normal_unit #(
  parameter int COORD_BITS = 24
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic [15:0]                   face_index_i,
  input  logic signed [COORD_BITS-1:0]  first_x_i,
  input  logic signed [COORD_BITS-1:0]  first_y_i,
  input  logic signed [COORD_BITS-1:0]  first_z_i,
  input  logic signed [COORD_BITS-1:0]  second_x_i,
  input  logic signed [COORD_BITS-1:0]  second_y_i,
  input  logic signed [COORD_BITS-1:0]  second_z_i,
  input  logic signed [COORD_BITS-1:0]  third_x_i,
  input  logic signed [COORD_BITS-1:0]  third_y_i,
  input  logic signed [COORD_BITS-1:0]  third_z_i,
  output logic                          valid_o,
  output logic [15:0]                   out_face_index_o,
  output logic signed [15:0]            normal_x_o,
  output logic signed [15:0]            normal_y_o,
  output logic signed [15:0]            normal_z_o,
  output logic                          degenerate_o
);

  `include "triangle_face_normal_unit_assert.svh"

  localparam int DW  = COORD_BITS + 1;
  localparam int PW  = 2 * DW;
  localparam int CW  = PW + 1;
  localparam int SB  = tfn_pkg::ScaledBits;
  localparam int ShW = $clog2(CW + 1);
  localparam int QB  = tfn_pkg::QBits;
  localparam int NW  = tfn_pkg::NormBits;

  assign busy = 1'b0;

  // Stage 1: edge vectors.
  logic                 v1_q;
  logic [15:0]          face1_q;
  logic signed [DW-1:0] e1_q [3];
  logic signed [DW-1:0] e2_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start;
    end
  end

  always_ff @(posedge clk_i) begin
    face1_q <= face_index_i;
    e1_q[0] <= DW'(second_x_i) - DW'(first_x_i);
    e1_q[1] <= DW'(second_y_i) - DW'(first_y_i);
    e1_q[2] <= DW'(second_z_i) - DW'(first_z_i);
    e2_q[0] <= DW'(third_x_i) - DW'(second_x_i);
    e2_q[1] <= DW'(third_y_i) - DW'(second_y_i);
    e2_q[2] <= DW'(third_z_i) - DW'(second_z_i);
  end

  // Stage 2: the six products.
  logic                 v2_q;
  logic [15:0]          face2_q;
  logic signed [PW-1:0] pa_q [3];
  logic signed [PW-1:0] pb_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    face2_q <= face1_q;
    pa_q[0] <= e1_q[1] * e2_q[2];
    pb_q[0] <= e1_q[2] * e2_q[1];
    pa_q[1] <= e1_q[2] * e2_q[0];
    pb_q[1] <= e1_q[0] * e2_q[2];
    pa_q[2] <= e1_q[0] * e2_q[1];
    pb_q[2] <= e1_q[1] * e2_q[0];
  end

  // Stage 3: exact cross product.
  logic                 v3_q;
  logic [15:0]          face3_q;
  logic signed [CW-1:0] c_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    face3_q <= face2_q;
    for (int i = 0; i < 3; i++) begin
      c_q[i] <= CW'(pa_q[i]) - CW'(pb_q[i]);
    end
  end

  // Stage 4: sign and magnitude.
  logic          v4_q;
  logic [15:0]   face4_q;
  logic [2:0]    neg4_q;
  logic [CW-1:0] mag4_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    face4_q <= face3_q;
    for (int i = 0; i < 3; i++) begin
      neg4_q[i] <= c_q[i][CW-1];
      mag4_q[i] <= c_q[i][CW-1] ? CW'(-c_q[i]) : CW'(c_q[i]);
    end
  end

  // Stage 5: common shift that brings every magnitude below 2^31.
  logic           v5_q;
  logic [15:0]    face5_q;
  logic [2:0]     neg5_q;
  logic [CW-1:0]  mag5_q [3];
  logic [ShW-1:0] sh5_q;
  logic           degen5_q;
  logic [CW-1:0]  mag_or;
  logic [ShW-1:0] sh_d;

  always_comb begin
    mag_or = mag4_q[0] | mag4_q[1] | mag4_q[2];
    sh_d   = '0;
    for (int i = SB; i < CW; i++) begin
      if (mag_or[i]) begin
        sh_d = ShW'(i - SB + 1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    face5_q  <= face4_q;
    neg5_q   <= neg4_q;
    mag5_q   <= mag4_q;
    sh5_q    <= sh_d;
    degen5_q <= (mag_or == '0);
  end

  // Stage 6: apply the shift.
  logic           v6_q;
  tfn_pkg::side_t side6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side6_q.face  <= face5_q;
    side6_q.neg   <= neg5_q;
    side6_q.degen <= degen5_q;
    for (int i = 0; i < 3; i++) begin
      side6_q.mag[i] <= SB'(mag5_q[i] >> sh5_q);
    end
  end

  // Stage 7: squares.
  logic             v7_q;
  tfn_pkg::side_t   side7_q;
  logic [2*SB-1:0]  sq7_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v7_q <= 1'b0;
    end else begin
      v7_q <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side7_q <= side6_q;
    for (int i = 0; i < 3; i++) begin
      sq7_q[i] <= side6_q.mag[i] * side6_q.mag[i];
    end
  end

  // Stage 8: squared length.
  logic                         v8_q;
  tfn_pkg::side_t               side8_q;
  logic [tfn_pkg::RadBits-1:0]  n8_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v8_q <= 1'b0;
    end else begin
      v8_q <= v7_q;
    end
  end

  always_ff @(posedge clk_i) begin
    side8_q <= side7_q;
    n8_q    <= tfn_pkg::RadBits'(sq7_q[0]) + tfn_pkg::RadBits'(sq7_q[1])
             + tfn_pkg::RadBits'(sq7_q[2]);
  end

  // Length.
  logic                          vr;
  logic [tfn_pkg::RootBits-1:0]  root;
  tfn_pkg::side_t                side_r;

  tfn_sqrt_pipe u_sqrt (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (v8_q),
    .radicand_i (n8_q),
    .side_i     (side8_q),
    .valid_o    (vr),
    .root_o     (root),
    .side_o     (side_r)
  );

  // Divider setup: q = floor((32768 * m + s) / (2 * s)) rounds 16384 * m / s to nearest.
  logic                         vp_q;
  tfn_pkg::tail_t               tailp_q;
  logic [tfn_pkg::NumBits-1:0]  nump_q [3];
  logic [tfn_pkg::DenBits-1:0]  denp_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vp_q <= 1'b0;
    end else begin
      vp_q <= vr;
    end
  end

  always_ff @(posedge clk_i) begin
    tailp_q.face  <= side_r.face;
    tailp_q.neg   <= side_r.neg;
    tailp_q.degen <= side_r.degen;
    denp_q        <= {root, 1'b0};
    for (int i = 0; i < 3; i++) begin
      nump_q[i] <= {2'b00, side_r.mag[i], QB'(0)} + tfn_pkg::NumBits'(root);
    end
  end

  logic          vd;
  logic [QB-1:0] quot [3];

  tfn_div_pipe u_div_x (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp_q),
    .num_i   (nump_q[0]),
    .den_i   (denp_q),
    .valid_o (vd),
    .quot_o  (quot[0])
  );

  tfn_div_pipe u_div_y (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp_q),
    .num_i   (nump_q[1]),
    .den_i   (denp_q),
    .valid_o (),
    .quot_o  (quot[1])
  );

  tfn_div_pipe u_div_z (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vp_q),
    .num_i   (nump_q[2]),
    .den_i   (denp_q),
    .valid_o (),
    .quot_o  (quot[2])
  );

  // Face index, signs and the zero flag wait alongside the dividers.
  tfn_pkg::tail_t tail_q [tfn_pkg::DivLat];

  always_ff @(posedge clk_i) begin
    tail_q[0] <= tailp_q;
    for (int i = 1; i < tfn_pkg::DivLat; i++) begin
      tail_q[i] <= tail_q[i-1];
    end
  end

  tfn_pkg::tail_t          tail_d;
  logic signed [NW-1:0]    norm_d [3];

  always_comb begin
    tail_d = tail_q[tfn_pkg::DivLat-1];
    for (int i = 0; i < 3; i++) begin
      if (tail_d.degen) begin
        norm_d[i] = '0;
      end else if (tail_d.neg[i]) begin
        norm_d[i] = NW'(-{1'b0, quot[i]});
      end else begin
        norm_d[i] = NW'({1'b0, quot[i]});
      end
    end
  end

  logic valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= vd;
    end
  end

  always_ff @(posedge clk_i) begin
    out_face_index_o <= tail_d.face;
    normal_x_o       <= norm_d[0];
    normal_y_o       <= norm_d[1];
    normal_z_o       <= norm_d[2];
    degenerate_o     <= tail_d.degen;
  end

  assign valid_o = valid_q;

  `TFN_ASSERT_DELAY(a_latency, start, tfn_pkg::PipeLatency, valid_o)
  `TFN_ASSERT_IMPLY(a_degen_zero, valid_o && degenerate_o,
                    normal_x_o == 0 && normal_y_o == 0 && normal_z_o == 0)
  `TFN_ASSERT_IMPLY(a_nonzero_unit, valid_o && !degenerate_o,
                    normal_x_o != 0 || normal_y_o != 0 || normal_z_o != 0)

endmodule

/* rtl/tfn_sqrt_pipe.sv */
// Pipelined integer square root, one result bit per stage.
// Depends on tfn_pkg for widths and the sideband type.
module tfn_sqrt_pipe (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [tfn_pkg::RadBits-1:0]   radicand_i,
  input  tfn_pkg::side_t                side_i,
  output logic                          valid_o,
  output logic [tfn_pkg::RootBits-1:0]  root_o,
  output tfn_pkg::side_t                side_o
);

  localparam int N  = tfn_pkg::SqrtLat;
  localparam int RB = tfn_pkg::RootBits;
  localparam int RW = RB + 2;

  logic                         vld_q  [N];
  logic [tfn_pkg::RadBits-1:0]  rad_q  [N];
  logic [RW-1:0]                rem_q  [N];
  logic [RB-1:0]                root_q [N];
  tfn_pkg::side_t               side_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic                        prev_vld;
    logic [tfn_pkg::RadBits-1:0] prev_rad;
    logic [RW-1:0]               prev_rem;
    logic [RB-1:0]               prev_root;
    tfn_pkg::side_t              prev_side;
    logic [RW+1:0]               rem_sh;
    logic [RW+1:0]               trial;
    logic [RW-1:0]               rem_d;
    logic [RB-1:0]               root_d;

    if (k == 0) begin : g_first
      assign prev_vld  = valid_i;
      assign prev_rad  = radicand_i;
      assign prev_rem  = '0;
      assign prev_root = '0;
      assign prev_side = side_i;
    end else begin : g_next
      assign prev_vld  = vld_q[k-1];
      assign prev_rad  = rad_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_root = root_q[k-1];
      assign prev_side = side_q[k-1];
    end

    always_comb begin
      rem_sh = {prev_rem, prev_rad[2*(N-1-k)+1 -: 2]};
      trial  = {2'b00, prev_root, 2'b01};
      if (rem_sh >= trial) begin
        rem_d  = RW'(rem_sh - trial);
        root_d = {prev_root[RB-2:0], 1'b1};
      end else begin
        rem_d  = RW'(rem_sh);
        root_d = {prev_root[RB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      rad_q[k]  <= prev_rad;
      rem_q[k]  <= rem_d;
      root_q[k] <= root_d;
      side_q[k] <= prev_side;
    end
  end

  assign valid_o = vld_q[N-1];
  assign root_o  = root_q[N-1];
  assign side_o  = side_q[N-1];

endmodule

/* rtl/tfn_div_pipe.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on tfn_pkg for widths; the quotient must fit in QBits.
module tfn_div_pipe (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         valid_i,
  input  logic [tfn_pkg::NumBits-1:0]  num_i,
  input  logic [tfn_pkg::DenBits-1:0]  den_i,
  output logic                         valid_o,
  output logic [tfn_pkg::QBits-1:0]    quot_o
);

  localparam int N  = tfn_pkg::DivLat;
  localparam int QB = tfn_pkg::QBits;
  localparam int DB = tfn_pkg::DenBits;
  localparam int NB = tfn_pkg::NumBits;

  logic          vld_q  [N];
  logic [NB-1:0] num_q  [N];
  logic [DB-1:0] den_q  [N];
  logic [DB-1:0] rem_q  [N];
  logic [QB-1:0] quot_q [N];

  for (genvar k = 0; k < N; k++) begin : g_stage
    logic          prev_vld;
    logic [NB-1:0] prev_num;
    logic [DB-1:0] prev_den;
    logic [DB-1:0] prev_rem;
    logic [QB-1:0] prev_quot;
    logic [DB:0]   rem_sh;
    logic [DB-1:0] rem_d;
    logic [QB-1:0] quot_d;

    if (k == 0) begin : g_first
      // The high part of the dividend is already below the divisor.
      assign prev_vld  = valid_i;
      assign prev_num  = num_i;
      assign prev_den  = den_i;
      assign prev_rem  = DB'(num_i[NB-1:QB]);
      assign prev_quot = '0;
    end else begin : g_next
      assign prev_vld  = vld_q[k-1];
      assign prev_num  = num_q[k-1];
      assign prev_den  = den_q[k-1];
      assign prev_rem  = rem_q[k-1];
      assign prev_quot = quot_q[k-1];
    end

    always_comb begin
      rem_sh = {prev_rem, prev_num[N-1-k]};
      if (rem_sh >= {1'b0, prev_den}) begin
        rem_d  = DB'(rem_sh - {1'b0, prev_den});
        quot_d = {prev_quot[QB-2:0], 1'b1};
      end else begin
        rem_d  = DB'(rem_sh);
        quot_d = {prev_quot[QB-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else begin
        vld_q[k] <= prev_vld;
      end
    end

    always_ff @(posedge clk_i) begin
      num_q[k]  <= prev_num;
      den_q[k]  <= prev_den;
      rem_q[k]  <= rem_d;
      quot_q[k] <= quot_d;
    end
  end

  assign valid_o = vld_q[N-1];
  assign quot_o  = quot_q[N-1];

endmodule

/* verif/triangle_face_normal_unit_tb.sv */
// Self-checking testbench for triangle_face_normal_unit: drives triangles,
// predicts the unit normal of each one and compares every result in order.
// Depends only on the RTL of the unit (tfn_pkg and its submodules).
`timescale 1ns / 100ps

module triangle_face_normal_unit_tb;

  localparam int CoordBits = 24;
  localparam int WatchLimit = 4000;
  localparam int DrainCycles = 80;

  typedef struct {
    logic [15:0]                 face;
    logic signed [CoordBits-1:0] v[9];  // x,y,z of the first, second, third vertex
  } triangle_t;

  typedef struct {
    logic [15:0]        face;
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
    logic               degen;
  } normal_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic start = 1'b0;
  logic busy;
  logic [15:0] face_index_i = '0;
  logic signed [CoordBits-1:0] coord[9];
  logic valid_o;
  logic [15:0] out_face_index_o;
  logic signed [15:0] normal_x_o, normal_y_o, normal_z_o;
  logic degenerate_o;
  logic busy_seen;

  normal_t expected_normals[$];
  int errors = 0;
  int quiet_cycles = 0;
  int idle_pct = 0;

  initial for (int i = 0; i < 9; i++) coord[i] = '0;

  always #6 clk_i = ~clk_i;

  triangle_face_normal_unit #(.COORD_BITS(CoordBits)) dut (
    .clk_i, .rst_ni, .start, .busy, .face_index_i,
    .first_x_i(coord[0]), .first_y_i(coord[1]), .first_z_i(coord[2]),
    .second_x_i(coord[3]), .second_y_i(coord[4]), .second_z_i(coord[5]),
    .third_x_i(coord[6]), .third_y_i(coord[7]), .third_z_i(coord[8]),
    .valid_o, .out_face_index_o, .normal_x_o, .normal_y_o, .normal_z_o, .degenerate_o
  );

  // busy only moves at rising edges, so the falling-edge copy is what the next edge sees.
  always @(negedge clk_i) busy_seen <= busy;

  function automatic normal_t face_normal(triangle_t t);
    logic signed [33:0] e1[3], e2[3];
    logic signed [67:0] c[3];
    logic [67:0] m[3];
    logic [67:0] sum_sq, root, trial, q;
    logic [2:0] neg;
    normal_t r;
    r.face = t.face;
    for (int i = 0; i < 3; i++) begin
      e1[i] = t.v[3+i] - t.v[i];
      e2[i] = t.v[6+i] - t.v[3+i];
    end
    c[0] = e1[1] * e2[2] - e1[2] * e2[1];
    c[1] = e1[2] * e2[0] - e1[0] * e2[2];
    c[2] = e1[0] * e2[1] - e1[1] * e2[0];
    for (int i = 0; i < 3; i++) begin
      neg[i] = c[i] < 0;
      m[i] = neg[i] ? -c[i] : c[i];
    end
    if ((m[0] | m[1] | m[2]) == 0) begin
      r.nx = '0; r.ny = '0; r.nz = '0; r.degen = 1'b1;
      return r;
    end
    // Shift all three together until every magnitude is below 2^31.
    while (((m[0] | m[1] | m[2]) >> 31) != 0)
      for (int i = 0; i < 3; i++) m[i] = m[i] >> 1;
    sum_sq = m[0] * m[0] + m[1] * m[1] + m[2] * m[2];
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      trial = root | (68'd1 << b);
      if (trial * trial <= sum_sq) root = trial;
    end
    for (int i = 0; i < 3; i++) begin
      q = (68'd32768 * m[i] + root) / (68'd2 * root);
      if (q > 16384) q = 16384;
      if (neg[i]) q = -q;
      if (i == 0) r.nx = q[15:0];
      else if (i == 1) r.ny = q[15:0];
      else r.nz = q[15:0];
    end
    r.degen = 1'b0;
    return r;
  endfunction

  // Appends one predicted result to the tail of the expected queue.
  function automatic void add_expected(normal_t n);
    expected_normals = {expected_normals, n};
  endfunction

  // Sends one triangle; start stays high into the next call unless a gap is drawn.
  task automatic send_triangle(triangle_t t);
    start <= 1'b1;
    face_index_i <= t.face;
    for (int i = 0; i < 9; i++) coord[i] <= t.v[i];
    do @(posedge clk_i); while (busy_seen);
    add_expected(face_normal(t));
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
  endtask

  function automatic triangle_t make_triangle(logic [15:0] f, int a0, int a1, int a2,
                                              int b0, int b1, int b2,
                                              int c0, int c1, int c2);
    triangle_t t;
    t.face = f;
    t.v[0] = a0; t.v[1] = a1; t.v[2] = a2;
    t.v[3] = b0; t.v[4] = b1; t.v[5] = b2;
    t.v[6] = c0; t.v[7] = c1; t.v[8] = c2;
    return t;
  endfunction

  function automatic int rand_coord(int span);
    int s;
    if (span == 0) return int'($signed($urandom_range(24'hFFFFFF) << 8)) >>> 8;
    s = $urandom_range(2 * span);
    return s - span;
  endfunction

  task automatic test_directed();
    localparam int Hi = 8388607;
    localparam int Lo = -8388608;
    idle_pct = 0;
    send_triangle(make_triangle(16'h0000, 0, 0, 0, 256, 0, 0, 256, 256, 0));
    send_triangle(make_triangle(16'hFFFF, 0, 0, 0, 0, 0, 256, 0, 256, 256));
    send_triangle(make_triangle(16'h0001, 0, 0, 0, 0, 256, 0, 0, 256, 256));
    // Degenerate: identical vertices, then collinear ones.
    send_triangle(make_triangle(16'h0002, 5, 5, 5, 5, 5, 5, 5, 5, 5));
    send_triangle(make_triangle(16'h0003, 0, 0, 0, 100, 200, 300, 200, 400, 600));
    send_triangle(make_triangle(16'h0004, Lo, Lo, Lo, Hi, Hi, Hi, Lo, Lo, Lo));
    // Extremes of the coordinate range, large products and block scaling.
    send_triangle(make_triangle(16'h8000, Lo, Lo, Lo, Hi, Lo, Lo, Hi, Hi, Lo));
    send_triangle(make_triangle(16'h7FFF, Lo, Hi, Lo, Hi, Lo, Hi, Lo, Lo, Hi));
    send_triangle(make_triangle(16'h5555, Hi, Hi, Hi, Lo, Hi, Lo, Hi, Lo, Lo));
    send_triangle(make_triangle(16'hAAAA, Hi, Lo, Hi, Lo, Lo, Hi, Hi, Hi, Lo));
    // Tiny cross products, equal components and negative components.
    send_triangle(make_triangle(16'h0010, 0, 0, 0, 1, 0, 0, 0, 1, 0));
    send_triangle(make_triangle(16'h0011, 0, 0, 0, 1, 0, 0, 1, 1, 1));
    send_triangle(make_triangle(16'h0012, 256, 0, 0, 0, 256, 0, 0, 0, 256));
    send_triangle(make_triangle(16'h0013, 0, 0, 256, 0, 256, 0, 256, 0, 0));
    send_triangle(make_triangle(16'h0014, -1, -1, -1, 0, -1, -1, 0, 0, -1));
    send_triangle(make_triangle(16'h0015, 0, 0, 0, 3, 0, 0, 3, 1, 0));
  endtask

  task automatic test_random(int count, int pct);
    triangle_t t;
    int span, mode;
    idle_pct = pct;
    for (int n = 0; n < count; n++) begin
      mode = $urandom_range(9);
      span = (mode < 5) ? 0 : (mode < 8) ? (1 << $urandom_range(20)) : 64;
      t.face = $urandom_range(16'hFFFF);
      for (int i = 0; i < 9; i++) t.v[i] = rand_coord(span);
      if (mode == 9) begin
        // Collinear or repeated vertices give a zero cross product.
        for (int i = 0; i < 3; i++)
          t.v[6+i] = ($urandom_range(1) != 0) ? t.v[3+i] : 2 * t.v[3+i] - t.v[i];
      end
      send_triangle(t);
    end
    start <= 1'b0;
    @(posedge clk_i);
  endtask

  always @(posedge clk_i) begin
    normal_t e;
    if (rst_ni && valid_o) begin
      if (expected_normals.size() == 0) begin
        $display("%0t: result for face %0h with none expected", $time, out_face_index_o);
        errors++;
      end else begin
        e = expected_normals.pop_front();
        if (out_face_index_o !== e.face || normal_x_o !== e.nx || normal_y_o !== e.ny ||
            normal_z_o !== e.nz || degenerate_o !== e.degen) begin
          $display("%0t: expected face %0h n=(%0d,%0d,%0d) deg %0b, got face %0h n=(%0d,%0d,%0d) deg %0b",
                   $time, e.face, e.nx, e.ny, e.nz, e.degen, out_face_index_o,
                   normal_x_o, normal_y_o, normal_z_o, degenerate_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: any transfer on either side resets the count.
  always @(posedge clk_i) begin
    if ((start && !busy_seen) || valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WatchLimit) begin
      $display("triangle_face_normal_unit: mismatch");
      $finish;
    end
  end

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(250, 0);
    test_random(250, 56);
    test_random(250, 38);
    test_random(250, 0);
    while (expected_normals.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (errors == 0) $display("triangle_face_normal_unit: match");
    else $display("triangle_face_normal_unit: mismatch");
    $finish;
  end

endmodule
